// ===== hdl/battery_internal_resistance_estimator_defines.svh =====
// Assertion macros shared by the estimator RTL.
`ifndef BATTERY_INTERNAL_RESISTANCE_ESTIMATOR_DEFINES_SVH
`define BATTERY_INTERNAL_RESISTANCE_ESTIMATOR_DEFINES_SVH

// Same-cycle implication on aclk, disabled in reset.
`define BIRE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("bire assertion failed");

// Next-cycle implication on aclk, disabled in reset.
`define BIRE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("bire assertion failed");

`endif

// ===== hdl/bire_pkg.sv =====
// Widths, constants and divider interface types for the resistance estimator.
package bire_pkg;

    localparam int VOLT_W    = 16;
    localparam int CURR_W    = 18;
    localparam int RES_W     = 18;
    localparam int CELL_W    = 5;
    localparam int SCALE_W   = 20;
    localparam int NUM_W     = VOLT_W + SCALE_W;
    localparam int DEN_W     = RES_W + CELL_W;
    localparam int DIV_STEPS = NUM_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [SCALE_W-1:0] UOHM_PER_OHM = SCALE_W'(1000000);
    localparam logic [RES_W-1:0]   R_LIMIT_UOHM = RES_W'(200000);

    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== hdl/bire_div.sv =====
// Restoring shift-subtract divider, one quotient bit per cycle.
module bire_div
    import bire_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  div_ctrl_t        ctrl,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output div_stat_t        stat,
    output logic [NUM_W-1:0] quotient
);

    logic [NUM_W-1:0]     quo_reg, quo_next;
    logic [DEN_W:0]       rem_reg, rem_next;
    logic [DEN_W-1:0]     den_reg, den_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DEN_W:0]       trial;
    logic                 fits;

    assign trial = {rem_reg[DEN_W-1:0], quo_reg[NUM_W-1]};
    assign fits  = (trial >= {1'b0, den_reg});

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctrl.start) begin
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? (trial - {1'b0, den_reg}) : trial;
            quo_next = {quo_reg[NUM_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

// ===== hdl/battery_internal_resistance_estimator.sv =====
// Battery internal resistance estimator: sequencer, sample state and output word.
// When an estimate is computed, the sample passes through DIFF, MUL, DIV (the bit-serial
// divider) and RESULT; otherwise DIFF goes straight to RESULT. A new sample is accepted
// only in IDLE, after the last word has been handed to the output register.
// Reset (aresetn low, synchronous): no previous sample, largest step 0, cell count 0.
`include "battery_internal_resistance_estimator_defines.svh"

module battery_internal_resistance_estimator
    import bire_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [CELL_W-1:0]        cfg_wr_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [VOLT_W-1:0]        s_voltage_mv,
    input  logic signed [CURR_W-1:0] s_current_ma,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_updated,
    output logic [RES_W-1:0]         m_resistance_uohm
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DIFF   = 3'd1;
    localparam logic [2:0] ST_MUL    = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_RESULT = 3'd4;

    logic [2:0]               state_reg, state_next;
    logic [CELL_W-1:0]        cells_reg, cells_next;
    logic                     have_prev_reg, have_prev_next;
    logic [VOLT_W-1:0]        prev_v_reg, prev_v_next;
    logic signed [CURR_W-1:0] prev_c_reg, prev_c_next;
    logic [RES_W-1:0]         largest_reg, largest_next;
    logic [VOLT_W-1:0]        in_v_reg, in_v_next;
    logic signed [CURR_W-1:0] in_c_reg, in_c_next;
    logic [VOLT_W-1:0]        dv_reg, dv_next;
    logic [RES_W-1:0]         step_reg, step_next;
    logic                     upd_reg, upd_next;
    logic [RES_W-1:0]         res_reg, res_next;
    logic                     m_valid_reg, m_valid_next;
    logic                     m_upd_reg, m_upd_next;
    logic [RES_W-1:0]         m_res_reg, m_res_next;

    logic signed [CURR_W:0]   di;
    logic [CURR_W:0]          di_abs;
    logic [RES_W-1:0]         step;
    logic [VOLT_W-1:0]        dv;
    logic                     larger;
    div_ctrl_t                div_ctrl;
    div_stat_t                div_stat;
    logic [NUM_W-1:0]         div_num;
    logic [DEN_W-1:0]         div_den;
    logic [NUM_W-1:0]         div_quo;
    logic                     out_free;

    assign di      = {in_c_reg[CURR_W-1], in_c_reg} - {prev_c_reg[CURR_W-1], prev_c_reg};
    assign di_abs  = di[CURR_W] ? (~di + 1'b1) : di;
    assign step    = di_abs[RES_W-1:0];
    assign dv      = (in_v_reg >= prev_v_reg) ? (in_v_reg - prev_v_reg)
                                              : (prev_v_reg - in_v_reg);
    assign larger  = have_prev_reg && (step > largest_reg);
    assign out_free = !m_valid_reg || m_ready;

    assign div_num = NUM_W'(dv_reg) * NUM_W'(UOHM_PER_OHM);
    assign div_den = DEN_W'(step_reg) * DEN_W'(cells_reg);
    assign div_ctrl.start = (state_reg == ST_MUL);

    bire_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (div_ctrl),
        .dividend (div_num),
        .divisor  (div_den),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    always_comb begin
        state_next     = state_reg;
        cells_next     = cfg_wr_en ? cfg_wr_data : cells_reg;
        have_prev_next = have_prev_reg;
        prev_v_next    = prev_v_reg;
        prev_c_next    = prev_c_reg;
        largest_next   = largest_reg;
        in_v_next      = in_v_reg;
        in_c_next      = in_c_reg;
        dv_next        = dv_reg;
        step_next      = step_reg;
        upd_next       = upd_reg;
        res_next       = res_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_upd_next     = m_upd_reg;
        m_res_next     = m_res_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    in_v_next  = s_voltage_mv;
                    in_c_next  = s_current_ma;
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF: begin
                dv_next        = dv;
                step_next      = step;
                prev_v_next    = in_v_reg;
                prev_c_next    = in_c_reg;
                have_prev_next = 1'b1;
                res_next       = '0;
                upd_next       = 1'b0;
                if (larger) begin
                    largest_next = step;
                end
                if (larger && (dv != '0) && (cells_reg != '0)) begin
                    state_next = ST_MUL;
                end else begin
                    state_next = ST_RESULT;
                end
            end
            ST_MUL: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    upd_next   = 1'b1;
                    res_next   = (div_quo > NUM_W'(R_LIMIT_UOHM)) ? R_LIMIT_UOHM
                                                                 : div_quo[RES_W-1:0];
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_upd_next   = upd_reg;
                    m_res_next   = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        in_v_reg  <= in_v_next;
        in_c_reg  <= in_c_next;
        dv_reg    <= dv_next;
        step_reg  <= step_next;
        upd_reg   <= upd_next;
        res_reg   <= res_next;
        m_upd_reg <= m_upd_next;
        m_res_reg <= m_res_next;
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cells_reg     <= '0;
            have_prev_reg <= 1'b0;
            prev_v_reg    <= '0;
            prev_c_reg    <= '0;
            largest_reg   <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cells_reg     <= cells_next;
            have_prev_reg <= have_prev_next;
            prev_v_reg    <= prev_v_next;
            prev_c_reg    <= prev_c_next;
            largest_reg   <= largest_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    assign s_ready           = (state_reg == ST_IDLE);
    assign m_valid           = m_valid_reg;
    assign m_updated         = m_upd_reg;
    assign m_resistance_uohm = m_res_reg;

    `BIRE_ASSERT_NEXT(a_accept_leaves_idle, s_valid && s_ready, !s_ready)
    `BIRE_ASSERT_SAME(a_div_blocks_input, div_stat.busy, !s_ready)
    `BIRE_ASSERT_SAME(a_no_update_zero, m_valid && !m_updated, m_resistance_uohm == '0)
    `BIRE_ASSERT_SAME(a_res_saturated, m_valid && m_updated, m_resistance_uohm <= R_LIMIT_UOHM)

endmodule

// ===== verif/tb_battery_internal_resistance_estimator.sv =====
// Self-checking testbench for the battery internal resistance estimator.
`timescale 1ns / 1ps

module tb_battery_internal_resistance_estimator
    import bire_pkg::*;
();

    localparam int IDLE_LIMIT  = 5000;
    localparam int PHASE_WORDS = 150;
    localparam int GROWTH_CAP  = 250000;
    localparam int CURR_MAX    = 131071;
    localparam int CURR_MIN    = -131072;
    localparam int VOLT_MAX    = 65535;

    typedef struct packed {
        logic [VOLT_W-1:0]        voltage;
        logic signed [CURR_W-1:0] current;
    } sample_t;

    typedef struct packed {
        logic             updated;
        logic [RES_W-1:0] resistance;
    } estimate_t;

    logic                     aclk;
    logic                     aresetn;
    logic                     cfg_wr_en;
    logic [CELL_W-1:0]        cfg_wr_data;
    logic                     s_valid;
    logic                     s_ready;
    logic [VOLT_W-1:0]        s_voltage_mv;
    logic signed [CURR_W-1:0] s_current_ma;
    logic                     m_valid;
    logic                     m_ready;
    logic                     m_updated;
    logic [RES_W-1:0]         m_resistance_uohm;

    battery_internal_resistance_estimator dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_voltage_mv      (s_voltage_mv),
        .s_current_ma      (s_current_ma),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_updated         (m_updated),
        .m_resistance_uohm (m_resistance_uohm)
    );

    sample_t   pending_samples[$];
    estimate_t expected_estimates[$];
    sample_t   next_sample;
    estimate_t oldest_estimate;

    // predictor state
    logic                     have_sample;
    logic [VOLT_W-1:0]        model_voltage;
    logic signed [CURR_W-1:0] model_current;
    int                       peak_step;
    logic [CELL_W-1:0]        cell_setting;

    // stimulus planning state
    int plan_current = 0;
    int plan_voltage = 0;
    int plan_peak    = 0;
    bit plan_started = 0;

    int   items_queued    = 0;
    int   items_accepted  = 0;
    int   results_seen    = 0;
    int   estimates_seen  = 0;
    int   saturated_seen  = 0;
    int   zero_seen       = 0;
    int   mismatch_count  = 0;
    int   settings_written = 0;
    int   idle_cycles     = 0;
    logic in_accepted     = 1'b0;

    int burst_left = 0;
    int gap_left   = 0;
    int hold_left  = 0;
    bit long_hold_done = 0;
    int stall_pct  = 0;
    int stall_span = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic estimate_t predict_estimate(input logic [VOLT_W-1:0] volt,
                                                   input logic signed [CURR_W-1:0] curr);
        int        cur_step;
        int        volt_step;
        longint    quotient;
        estimate_t est;
        est = '0;
        if (have_sample) begin
            cur_step  = int'(curr) - int'(model_current);
            volt_step = int'(volt) - int'(model_voltage);
            if (cur_step < 0) cur_step = -cur_step;
            if (volt_step < 0) volt_step = -volt_step;
            if (cur_step > peak_step) begin
                peak_step = cur_step;
                if (volt_step != 0 && cell_setting != 0) begin
                    quotient = (longint'(volt_step) * longint'(UOHM_PER_OHM))
                               / (longint'(cur_step) * longint'(cell_setting));
                    if (quotient > longint'(R_LIMIT_UOHM)) quotient = longint'(R_LIMIT_UOHM);
                    est.updated    = 1'b1;
                    est.resistance = RES_W'(quotient);
                end
            end
        end
        model_voltage = volt;
        model_current = curr;
        have_sample   = 1'b1;
        return est;
    endfunction

    // model update and acceptance on the input side
    always @(posedge aclk) begin
        in_accepted <= aresetn && s_valid && s_ready;
        if (!aresetn) begin
            have_sample   = 1'b0;
            model_voltage = '0;
            model_current = '0;
            peak_step     = 0;
            cell_setting  = '0;
        end else begin
            if (cfg_wr_en) cell_setting = cfg_wr_data;
            if (s_valid && s_ready) begin
                expected_estimates.push_back(predict_estimate(s_voltage_mv, s_current_ma));
                items_accepted++;
            end
        end
    end

    // sender: bursts with random gaps
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_accepted) begin
            if (gap_left != 0 || pending_samples.size() == 0) begin
                s_valid <= 1'b0;
                if (gap_left != 0) gap_left <= gap_left - 1;
            end else begin
                next_sample = pending_samples.pop_front();
                s_valid      <= 1'b1;
                s_voltage_mv <= next_sample.voltage;
                s_current_ma <= next_sample.current;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // receiver: stall pattern plus one long hold-off while words are still offered
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!long_hold_done && results_seen >= 300 && items_accepted < items_queued) begin
            m_ready        <= 1'b0;
            hold_left      <= 700;
            long_hold_done <= 1'b1;
        end else begin
            if (stall_span == 0) begin
                case ($urandom_range(0, 2))
                    0: stall_pct <= 0;
                    1: stall_pct <= 30;
                    default: stall_pct <= 75;
                endcase
                stall_span <= $urandom_range(20, 200);
            end else begin
                stall_span <= stall_span - 1;
            end
            m_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // result check and watchdog
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_estimates.size() == 0) begin
                $error("unexpected result word: updated %0d, resistance_uohm %0d",
                       m_updated, m_resistance_uohm);
                mismatch_count++;
            end else begin
                oldest_estimate = expected_estimates.pop_front();
                if (m_updated !== oldest_estimate.updated) begin
                    $error("updated mismatch: expected %0d, got %0d",
                           oldest_estimate.updated, m_updated);
                    mismatch_count++;
                end
                if (m_resistance_uohm !== oldest_estimate.resistance) begin
                    $error("resistance_uohm mismatch: expected %0d, got %0d",
                           oldest_estimate.resistance, m_resistance_uohm);
                    mismatch_count++;
                end
                if (oldest_estimate.updated) begin
                    estimates_seen++;
                    if (oldest_estimate.resistance == R_LIMIT_UOHM) saturated_seen++;
                    if (oldest_estimate.resistance == 0) zero_seen++;
                end
            end
        end
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic queue_sample(input int volt, input int curr);
        sample_t s;
        int      jump;
        s.voltage = volt[VOLT_W-1:0];
        s.current = curr[CURR_W-1:0];
        if (plan_started) begin
            jump = curr - plan_current;
            if (jump < 0) jump = -jump;
            if (jump > plan_peak) plan_peak = jump;
        end
        plan_started = 1;
        plan_current = curr;
        plan_voltage = volt;
        pending_samples.push_back(s);
        items_queued++;
    endtask

    task automatic queue_random_sample();
        int volt;
        int curr;
        int want;
        int reach_up;
        int reach_down;
        case ($urandom_range(0, 4)) inside
            0: volt = plan_voltage;
            1, 2: volt = plan_voltage + $urandom_range(0, 600) - 300;
            default: volt = $urandom_range(0, VOLT_MAX);
        endcase
        if (volt < 0) volt = 0;
        if (volt > VOLT_MAX) volt = VOLT_MAX;
        reach_up   = CURR_MAX - plan_current;
        reach_down = plan_current - CURR_MIN;
        if ($urandom_range(0, 99) < 55 && plan_peak < GROWTH_CAP) begin
            // grow the step toward the far rail; jump to the rail if out of reach
            want = plan_peak + 1 + $urandom_range(0, (GROWTH_CAP - plan_peak) / 64);
            if (reach_up >= reach_down)
                curr = (want <= reach_up) ? plan_current + want : CURR_MAX;
            else
                curr = (want <= reach_down) ? plan_current - want : CURR_MIN;
        end else begin
            want = $urandom_range(0, plan_peak);
            curr = $urandom_range(0, 1) ? plan_current + want : plan_current - want;
            if (curr > CURR_MAX) curr = CURR_MAX;
            if (curr < CURR_MIN) curr = CURR_MIN;
        end
        queue_sample(volt, curr);
    endtask

    task automatic wait_drained();
        while (items_accepted != items_queued || expected_estimates.size() != 0)
            @(negedge aclk);
    endtask

    task automatic set_cell_count(input int cells);
        wait_drained();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cells[CELL_W-1:0];
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        settings_written++;
    endtask

    initial begin
        int random_cells[6];
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        set_cell_count(3);
        queue_sample(0, -5);
        queue_sample(VOLT_MAX, 5);
        queue_sample(VOLT_MAX, -10);
        queue_sample(65534, 5);
        queue_sample(65533, 25);
        queue_sample(40000, 0);

        set_cell_count(0);
        queue_sample(40100, 40);
        queue_sample(40000, -10);

        set_cell_count(1);
        queue_sample(40020, 90);
        queue_sample(40021, -11);
        queue_sample(40041, 91);

        random_cells = '{1, 16, 0, 31, $urandom_range(2, 15), $urandom_range(17, 30)};
        foreach (random_cells[p]) begin
            set_cell_count(random_cells[p]);
            repeat (PHASE_WORDS) queue_random_sample();
        end

        // full-swing tail at the largest cell count
        set_cell_count(31);
        queue_sample(100, 0);
        queue_sample(100, CURR_MIN + 1);
        queue_sample(101, CURR_MAX - 1);
        queue_sample(VOLT_MAX, CURR_MIN);
        queue_sample(0, CURR_MAX);

        wait_drained();
        repeat (60) @(negedge aclk);
        if (expected_estimates.size() != 0) begin
            $error("%0d expected result words never arrived", expected_estimates.size());
            mismatch_count++;
        end
        $display("run: %0d sample words checked, %0d estimates (%0d saturated, %0d zero)",
                 results_seen, estimates_seen, saturated_seen, zero_seen);
        $display("run: %0d cell-count writes from 0 to 31, %0d mismatches",
                 settings_written, mismatch_count);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
